FILE: rtl/hpa_pkg.sv
// ----------------------------------------------------------------------------
// hpa_pkg: shared types and constants of the handle pool allocator
// Request and status codes, handle and index widths, and the structs that
// carry control and status between the free FIFO, the in-use map and the top.
// ----------------------------------------------------------------------------
package hpa_pkg;

    localparam int POOL_SIZE   = 256;
    localparam int HANDLE_W    = 8;
    localparam int FUNC_W      = 2;
    localparam int STATUS_W    = 2;
    localparam int LIMIT_W     = 9;
    localparam int DATA_W      = 32;
    localparam int PADDR_W     = 3;

    // Handles wider than the granted_handle field never exist, so the map and
    // the FIFO only need the smaller of the pool size and the handle span.
    localparam int HANDLE_SPAN = 1 << HANDLE_W;
    localparam int MAP_DEPTH   = (POOL_SIZE < HANDLE_SPAN) ? POOL_SIZE : HANDLE_SPAN;
    localparam int MAP_AW      = (MAP_DEPTH > 1) ? $clog2(MAP_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(MAP_DEPTH + 1);

    localparam logic [LIMIT_W-1:0] LIMIT_RESET   = LIMIT_W'(256);
    localparam logic [LIMIT_W-1:0] MAP_DEPTH_LIM = LIMIT_W'(MAP_DEPTH);

    localparam logic [FUNC_W-1:0] FUNC_ALLOC   = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_TRY     = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_RELEASE = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NONE_FREE = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EXHAUSTED = 2'd2;
    localparam logic [STATUS_W-1:0] ST_INVALID   = 2'd3;

    typedef logic [HANDLE_W-1:0] handle_t;
    typedef logic [MAP_AW-1:0]   map_idx_t;

    typedef struct packed {
        logic    push;
        handle_t push_handle;
        logic    pop;
    } fifo_ctrl_t;

    typedef struct packed {
        logic    not_empty;
        handle_t head_handle;
    } fifo_stat_t;

    typedef struct packed {
        map_idx_t rd_idx;
        logic     set_en;
        map_idx_t set_idx;
        logic     clr_en;
        map_idx_t clr_idx;
    } map_ctrl_t;

endpackage

FILE: rtl/hpa_free_fifo.sv
// ----------------------------------------------------------------------------
// hpa_free_fifo: FIFO of released handles
// Memory-backed queue with a prefetched head entry, so the oldest handle is
// available in the same cycle that a pop is decided.
// ----------------------------------------------------------------------------
module hpa_free_fifo (
    input  logic               clk,
    input  logic               rst_n,
    input  hpa_pkg::fifo_ctrl_t ctrl,
    output hpa_pkg::fifo_stat_t stat
);
    import hpa_pkg::*;

    handle_t           mem [MAP_DEPTH];
    map_idx_t          head_reg;
    map_idx_t          head_next;
    map_idx_t          tail_reg;
    map_idx_t          tail_next;
    logic [QCNT_W-1:0] count_reg;
    logic [QCNT_W-1:0] count_next;
    handle_t           head_data_reg;
    logic              full;
    logic              do_push;
    logic              do_pop;

    function automatic map_idx_t wrap_inc(input map_idx_t pos);
        map_idx_t res;
        if (pos == MAP_AW'(MAP_DEPTH - 1))
        begin
            res = '0;
        end
        else
        begin
            res = pos + 1'b1;
        end
        return res;
    endfunction

    assign full    = (count_reg == QCNT_W'(MAP_DEPTH));
    assign do_push = ctrl.push && !full;
    assign do_pop  = ctrl.pop && (count_reg != '0);

    always_comb
    begin
        head_next  = do_pop ? wrap_inc(head_reg) : head_reg;
        tail_next  = do_push ? wrap_inc(tail_reg) : tail_reg;
        count_next = count_reg;
        if (do_push)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    // Write at the tail; read ahead at the next head, forwarding a write that
    // lands on it (push into an empty queue).
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[tail_reg] <= ctrl.push_handle;
        end
        if (do_push && (tail_reg == head_next))
        begin
            head_data_reg <= ctrl.push_handle;
        end
        else
        begin
            head_data_reg <= mem[head_next];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    assign stat.not_empty   = (count_reg != '0);
    assign stat.head_handle = head_data_reg;

endmodule

FILE: rtl/hpa_use_map.sv
// ----------------------------------------------------------------------------
// hpa_use_map: in-use flags of all handles
// One flip-flop per handle, cleared by reset; one read, one set and one
// clear port.
// ----------------------------------------------------------------------------
module hpa_use_map (
    input  logic              clk,
    input  logic              rst_n,
    input  hpa_pkg::map_ctrl_t ctrl,
    output logic              in_use
);
    import hpa_pkg::*;

    logic [MAP_DEPTH-1:0] map_reg;
    logic [MAP_DEPTH-1:0] map_next;

    always_comb
    begin
        map_next = map_reg;
        if (ctrl.set_en)
        begin
            map_next[ctrl.set_idx] = 1'b1;
        end
        if (ctrl.clr_en)
        begin
            map_next[ctrl.clr_idx] = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            map_reg <= '0;
        end
        else
        begin
            map_reg <= map_next;
        end
    end

    assign in_use = map_reg[ctrl.rd_idx];

endmodule

FILE: rtl/handle_pool_allocator.sv
// ----------------------------------------------------------------------------
// handle_pool_allocator: FIFO free-list handle allocator
// Hands out numbered handles, reusing released ones oldest first, and checks
// releases against an in-use map.
// ----------------------------------------------------------------------------
// A request (func, release_handle) is taken at every clock edge where start
// is high; busy stays low, so one request per cycle is sustained without
// gaps. Each request yields exactly one result, strobed by result_valid for
// a single cycle: the accepting edge loads the request register, then the
// result register is loaded as the pool state updates. This single
// registered decide step lets back-to-back requests see each other's
// effects in order. The receiver has no way to stall: it must take every
// result in its strobe cycle. The in-use map lives in flip-flops cleared by
// reset, so there is no clearing pass and requests may start right after
// reset. handle_limit (APB, offset 0x0) must be written by the user only
// while no request is in flight; the block itself does not enforce it.
// ----------------------------------------------------------------------------
module handle_pool_allocator (
    input  logic                            clk,
    input  logic                            rst_n,
    // request channel
    input  logic                            start,
    output logic                            busy,
    input  logic [hpa_pkg::FUNC_W-1:0]      func,
    input  logic [hpa_pkg::HANDLE_W-1:0]    release_handle,
    // result channel
    output logic                            result_valid,
    output logic [hpa_pkg::HANDLE_W-1:0]    granted_handle,
    output logic [hpa_pkg::STATUS_W-1:0]    status,
    // configuration
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [hpa_pkg::PADDR_W-1:0]     paddr,
    input  logic [hpa_pkg::DATA_W-1:0]      pwdata,
    output logic [hpa_pkg::DATA_W-1:0]      prdata,
    output logic                            pready
);
    import hpa_pkg::*;

    localparam logic REG_LIMIT = 1'b0;

    // request register
    logic                req_valid_reg;
    logic [FUNC_W-1:0]   func_reg;
    handle_t             rel_reg;

    // pool state
    logic [LIMIT_W-1:0]  limit_reg;
    logic [LIMIT_W-1:0]  created_reg;
    logic [LIMIT_W-1:0]  created_next;
    logic [LIMIT_W-1:0]  eff_limit;

    // result register
    logic                result_valid_reg;
    handle_t             granted_reg;
    handle_t             granted_next;
    logic [STATUS_W-1:0] status_reg;
    logic [STATUS_W-1:0] status_next;

    fifo_ctrl_t          fifo_ctrl;
    fifo_stat_t          fifo_stat;
    map_ctrl_t           map_ctrl;
    logic                rel_in_use;
    logic                rel_in_pool;
    logic                cfg_write;

    hpa_free_fifo u_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (fifo_ctrl),
        .stat  (fifo_stat)
    );

    hpa_use_map u_map (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (map_ctrl),
        .in_use (rel_in_use)
    );

    // Configuration: one register, handle_limit, at word 0.
    assign cfg_write = psel && penable && pwrite;
    assign pready    = 1'b1;
    assign prdata    = (paddr[2] == REG_LIMIT) ? DATA_W'(limit_reg) : '0;

    // Never create more handles than the map can track.
    assign eff_limit   = (limit_reg > MAP_DEPTH_LIM) ? MAP_DEPTH_LIM : limit_reg;
    assign rel_in_pool = ({1'b0, rel_reg} < LIMIT_W'(MAP_DEPTH));

    // Decide the request held in the request register.
    always_comb
    begin
        granted_next          = '0;
        status_next           = ST_OK;
        created_next          = created_reg;
        fifo_ctrl.push        = 1'b0;
        fifo_ctrl.push_handle = rel_reg;
        fifo_ctrl.pop         = 1'b0;
        map_ctrl.rd_idx       = rel_reg[MAP_AW-1:0];
        map_ctrl.set_en       = 1'b0;
        map_ctrl.set_idx      = fifo_stat.head_handle[MAP_AW-1:0];
        map_ctrl.clr_en       = 1'b0;
        map_ctrl.clr_idx      = rel_reg[MAP_AW-1:0];
        case (func_reg)
            FUNC_ALLOC, FUNC_TRY:
            begin
                if (fifo_stat.not_empty)
                begin
                    // reuse the oldest released handle
                    granted_next    = fifo_stat.head_handle;
                    fifo_ctrl.pop   = req_valid_reg;
                    map_ctrl.set_en = req_valid_reg;
                end
                else if (func_reg == FUNC_TRY)
                begin
                    status_next = ST_NONE_FREE;
                end
                else if (created_reg < eff_limit)
                begin
                    // create the next fresh handle
                    granted_next     = created_reg[HANDLE_W-1:0];
                    map_ctrl.set_en  = req_valid_reg;
                    map_ctrl.set_idx = created_reg[MAP_AW-1:0];
                    if (req_valid_reg)
                    begin
                        created_next = created_reg + 1'b1;
                    end
                end
                else
                begin
                    status_next = ST_EXHAUSTED;
                end
            end
            FUNC_RELEASE:
            begin
                if (rel_in_pool && rel_in_use)
                begin
                    map_ctrl.clr_en = req_valid_reg;
                    fifo_ctrl.push  = req_valid_reg;
                end
                else
                begin
                    status_next = ST_INVALID;
                end
            end
            default:
            begin
                status_next = ST_NONE_FREE;
            end
        endcase
    end

    // Payload registers: load the request on accept, the result on decide.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            func_reg <= func;
            rel_reg  <= release_handle;
        end
        if (req_valid_reg)
        begin
            granted_reg <= granted_next;
            status_reg  <= status_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid_reg    <= 1'b0;
            result_valid_reg <= 1'b0;
            created_reg      <= '0;
            limit_reg        <= LIMIT_RESET;
        end
        else
        begin
            req_valid_reg    <= start;
            result_valid_reg <= req_valid_reg;
            created_reg      <= created_next;
            if (cfg_write && (paddr[2] == REG_LIMIT))
            begin
                limit_reg <= pwdata[LIMIT_W-1:0];
            end
        end
    end

    assign busy           = 1'b0;
    assign result_valid   = result_valid_reg;
    assign granted_handle = granted_reg;
    assign status         = status_reg;

endmodule

FILE: rtl/hpa_checker.sv
// ----------------------------------------------------------------------------
// hpa_checker: port-level checks of the handle pool allocator
// Watches request and result beats and the meaning of result codes.
// ----------------------------------------------------------------------------
module hpa_checker (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         start,
    input logic                         busy,
    input logic [hpa_pkg::FUNC_W-1:0]   func,
    input logic                         result_valid,
    input logic [hpa_pkg::HANDLE_W-1:0] granted_handle,
    input logic [hpa_pkg::STATUS_W-1:0] status
);
    import hpa_pkg::*;

    // every accepted request beat gives a later result beat
    a_req_to_result: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> ##1 result_valid)
        else $error("request beat without result beat");

    // no result beat without an earlier request beat
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> $past(start && !busy, 2))
        else $error("result beat without request");

    // failed requests hand out handle zero
    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && (status != ST_OK)) |-> (granted_handle == '0))
        else $error("nonzero handle on failed request");

    // exhausted only answers allocate, invalid only answers release
    a_exhausted_src: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && (status == ST_EXHAUSTED)) |-> ($past(func, 2) == FUNC_ALLOC))
        else $error("exhausted status on a non-allocate request");

    a_invalid_src: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && (status == ST_INVALID)) |-> ($past(func, 2) == FUNC_RELEASE))
        else $error("invalid status on a non-release request");

endmodule

bind handle_pool_allocator hpa_checker u_hpa_checker (.*);
